// File: design/alsd_pkg.sv
// alsd_pkg: shared types and constants for the averaged light switch.
// Holds the mode enum, event and register codes, reset values, and the
// per-item tag that travels down the pipeline. No dependencies.
package alsd_pkg;

	typedef enum logic [1:0] {
		MODE_OFF      = 2'd0,
		MODE_ON_HOLD  = 2'd1,
		MODE_ON       = 2'd2,
		MODE_OFF_HOLD = 2'd3
	} mode_t;

	typedef logic [1:0] event_t;
	localparam event_t EV_NONE = 2'd0;
	localparam event_t EV_ON   = 2'd1;
	localparam event_t EV_OFF  = 2'd2;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_THRESHOLD = 2'd0;
	localparam cfg_idx_t CFG_ON_HOLD   = 2'd1;
	localparam cfg_idx_t CFG_OFF_HOLD  = 2'd2;

	localparam logic [15:0] THRESHOLD_RST = 16'd2000;
	localparam logic [7:0]  ON_HOLD_RST   = 8'd50;
	localparam logic [7:0]  OFF_HOLD_RST  = 8'd100;

	// Tag carried alongside each word: its tick stamp and whether the ring
	// is full once this word is in, i.e. whether this word makes a decision.
	typedef struct packed {
		logic [31:0] stamp;
		logic        decide;
	} meta_t;

endpackage

// File: design/averaged_light_switch_with_dwell.sv
// averaged_light_switch_with_dwell: moving-average light switch, top level.
// Path: the accepting edge loads s1; s2, s3 and the result register load in that order.
// Throughput: one word per cycle unless out_ready stalls; stages advance independently.
// Reset (arst_n low): threshold 2000, holds 50/100, ring empty, mode off, tick count 0.
// The ring RAM needs no clearing pass: slots not yet written count as zero.
// Depends on alsd_pkg, alsd_window, alsd_div, alsd_ctrl.
module averaged_light_switch_with_dwell #(
	parameter int WINDOW = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	// sample channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] sample,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        light_on,
	output logic [1:0]  event_res,
	output logic [31:0] stamp,
	output logic [15:0] average,
	output logic        average_valid,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Sum of a full window of 16-bit words.
	localparam int SUM_W = 16 + $clog2(WINDOW);

	// Configuration registers
	logic [15:0] threshold_q;
	logic [7:0]  on_hold_q;
	logic [7:0]  off_hold_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= alsd_pkg::THRESHOLD_RST;
			on_hold_q   <= alsd_pkg::ON_HOLD_RST;
			off_hold_q  <= alsd_pkg::OFF_HOLD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				alsd_pkg::CFG_THRESHOLD: threshold_q <= cfg_data;
				alsd_pkg::CFG_ON_HOLD:   on_hold_q   <= cfg_data[7:0];
				alsd_pkg::CFG_OFF_HOLD:  off_hold_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control. Each stage loads when it is empty or its
	// contents move on, so an output stall only backs up full stages.
	//   s1: displaced ring word arrives, running sum updated
	//   s2: sum registered
	//   s3: product registered, average and mode decided
	//   out: result register
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic load_s1, load_s2, load_s3, load_out;
	logic accept;

	assign load_out = !out_valid_q || out_ready;
	assign load_s3  = !valid_s3 || load_out;
	assign load_s2  = !valid_s2 || load_s3;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_ready = load_s1;
	assign accept   = in_valid && load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1)  valid_s1    <= in_valid;
			if (load_s2)  valid_s2    <= valid_s1;
			if (load_s3)  valid_s3    <= valid_s2;
			if (load_out) out_valid_q <= valid_s3;
		end
	end

	// Ring, tick counter and running sum
	logic [SUM_W-1:0] sum_nxt;
	alsd_pkg::meta_t  meta_s1, meta_s2, meta_s3;

	alsd_window #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.load_s1(load_s1),
		.fire_s1(valid_s1 && load_s2),
		.sample (sample),
		.sum_nxt(sum_nxt),
		.meta_s1(meta_s1)
	);

	always_ff @(posedge clk) begin
		if (load_s2) meta_s2 <= meta_s1;
		if (load_s3) meta_s3 <= meta_s2;
	end

	// Average by constant reciprocal
	logic [15:0] avg_s3;

	alsd_div #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_div (
		.clk    (clk),
		.load_s2(load_s2),
		.load_s3(load_s3),
		.sum_in (sum_nxt),
		.average(avg_s3)
	);

	// Mode machine; its state advances as the word leaves s3
	logic             light_on_d;
	alsd_pkg::event_t event_d;

	alsd_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (valid_s3 && load_out),
		.decide        (meta_s3.decide),
		.average       (avg_s3),
		.threshold     (threshold_q),
		.on_hold_ticks (on_hold_q),
		.off_hold_ticks(off_hold_q),
		.light_on      (light_on_d),
		.event_res     (event_d)
	);

	// Result register; average reads zero until the ring is full
	always_ff @(posedge clk) begin
		if (load_out) begin
			light_on      <= light_on_d;
			event_res     <= event_d;
			stamp         <= meta_s3.stamp;
			average       <= meta_s3.decide ? avg_s3 : 16'd0;
			average_valid <= meta_s3.decide;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: design/alsd_ram.sv
// alsd_ram: generic simple dual-port RAM, one write and one read port.
// Read data is registered and returns the old contents on a same-address write.
// No dependencies.
module alsd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 20
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/alsd_window.sv
// alsd_window: sample ring, fill tracking, tick counter and running sum.
// Depends on alsd_pkg and alsd_ram.
module alsd_window #(
	parameter int WINDOW = 20,
	parameter int SUM_W  = 21
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               load_s1,
	input  logic               fire_s1,
	input  logic [15:0]        sample,
	output logic [SUM_W-1:0]   sum_nxt,
	output alsd_pkg::meta_t    meta_s1
);

	localparam int SLOT_W = $clog2(WINDOW);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] fill_q;
	logic              wrapped_q;
	logic [31:0]       tick_q;
	logic [SUM_W-1:0]  running_sum_q;
	logic [15:0]       sample_s1;
	logic              old_ok_s1;
	logic [15:0]       old_rd;
	logic [15:0]       old_val;

	// Write the new word and fetch the one it displaces in the same cycle.
	alsd_ram #(.WIDTH(16), .DEPTH(WINDOW)) u_ring (
		.clk  (clk),
		.we   (accept),
		.waddr(slot_q),
		.wdata(sample),
		.re   (accept),
		.raddr(slot_q),
		.rdata(old_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			fill_q    <= '0;
			wrapped_q <= 1'b0;
			tick_q    <= '0;
		end else if (accept) begin
			tick_q <= tick_q + 32'd1;
			if (slot_q == LAST_SLOT) begin
				slot_q    <= '0;
				wrapped_q <= 1'b1;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
			if (fill_q != LAST_SLOT) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			sample_s1      <= sample;
			old_ok_s1      <= wrapped_q;
			meta_s1.stamp  <= tick_q + 32'd1;
			meta_s1.decide <= (fill_q == LAST_SLOT);
		end
	end

	// Slots not yet written since reset count as zero.
	assign old_val = old_ok_s1 ? old_rd : 16'd0;
	assign sum_nxt = running_sum_q - SUM_W'(old_val) + SUM_W'(sample_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
		end else if (fire_s1) begin
			running_sum_q <= sum_nxt;
		end
	end

endmodule

// File: design/alsd_div.sv
// alsd_div: window average by reciprocal multiply, two register stages.
// Exact floor(sum / WINDOW) for every sum below 2^SUM_W whose quotient fits 16 bits. No dependencies.
module alsd_div #(
	parameter int WINDOW = 20,
	parameter int SUM_W  = 21
) (
	input  logic             clk,
	input  logic             load_s2,
	input  logic             load_s3,
	input  logic [SUM_W-1:0] sum_in,
	output logic [15:0]      average
);

	localparam int    L_W    = $clog2(WINDOW);
	localparam int    SH     = SUM_W + L_W;
	localparam int    REC_W  = SUM_W + 2;
	localparam int    PROD_W = SUM_W + REC_W;
	localparam longint RECIP_L = ((64'd1 << SH) + WINDOW - 1) / WINDOW;
	localparam logic [REC_W-1:0] RECIP = REC_W'(RECIP_L);

	logic [SUM_W-1:0]  sum_s2;
	logic [PROD_W-1:0] prod_s3;

	always_ff @(posedge clk) begin
		if (load_s2) begin
			sum_s2 <= sum_in;
		end
		if (load_s3) begin
			prod_s3 <= PROD_W'(sum_s2) * PROD_W'(RECIP);
		end
	end

	assign average = prod_s3[SH +: 16];

endmodule

// File: design/alsd_ctrl.sv
// alsd_ctrl: four-mode switch machine with hold counter.
// Depends on alsd_pkg.
module alsd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic                decide,
	input  logic [15:0]         average,
	input  logic [15:0]         threshold,
	input  logic [7:0]          on_hold_ticks,
	input  logic [7:0]          off_hold_ticks,
	output logic                light_on,
	output alsd_pkg::event_t    event_res
);

	alsd_pkg::mode_t mode_q, mode_d;
	logic [7:0]      hold_q, hold_d;
	logic [7:0]      hold_inc;
	logic            below, above;

	assign below    = average < threshold;
	assign above    = average > threshold;
	assign hold_inc = hold_q + 8'd1;

	// next state
	always_comb begin
		mode_d = mode_q;
		hold_d = hold_q;
		if (decide) begin
			case (mode_q)
				alsd_pkg::MODE_OFF: begin
					if (below) mode_d = alsd_pkg::MODE_ON_HOLD;
				end
				alsd_pkg::MODE_ON_HOLD: begin
					hold_d = hold_inc;
					if (hold_inc == on_hold_ticks) begin
						hold_d = 8'd0;
						mode_d = above ? alsd_pkg::MODE_OFF_HOLD : alsd_pkg::MODE_ON;
					end
				end
				alsd_pkg::MODE_ON: begin
					if (above) mode_d = alsd_pkg::MODE_OFF_HOLD;
				end
				alsd_pkg::MODE_OFF_HOLD: begin
					hold_d = hold_inc;
					if (hold_inc == off_hold_ticks) begin
						hold_d = 8'd0;
						mode_d = below ? alsd_pkg::MODE_ON_HOLD : alsd_pkg::MODE_OFF;
					end
				end
				default: begin
					mode_d = alsd_pkg::MODE_OFF;
				end
			endcase
		end
	end

	// outputs: an event is any entry into a hold from elsewhere
	always_comb begin
		light_on  = (mode_d == alsd_pkg::MODE_ON_HOLD) || (mode_d == alsd_pkg::MODE_ON);
		event_res = alsd_pkg::EV_NONE;
		if (mode_d == alsd_pkg::MODE_ON_HOLD && mode_q != alsd_pkg::MODE_ON_HOLD) begin
			event_res = alsd_pkg::EV_ON;
		end else if (mode_d == alsd_pkg::MODE_OFF_HOLD &&
				mode_q != alsd_pkg::MODE_OFF_HOLD) begin
			event_res = alsd_pkg::EV_OFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= alsd_pkg::MODE_OFF;
			hold_q <= 8'd0;
		end else if (fire) begin
			mode_q <= mode_d;
			hold_q <= hold_d;
		end
	end

endmodule

// File: design/alsd_checker.sv
// alsd_checker: port-level assertions for the averaged light switch.
// Bound to averaged_light_switch_with_dwell; depends on alsd_pkg.
module alsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        light_on,
	input logic [1:0]  event_res,
	input logic [31:0] stamp,
	input logic [15:0] average,
	input logic        average_valid
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(stamp) && $stable(average))
		else $error("result changed while stalled");

	// Consecutive results carry consecutive stamps.
	a_stamp_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) ##1 out_valid |-> stamp == $past(stamp) + 32'd1)
		else $error("stamp not consecutive");

	// An event agrees with the light state it reports.
	a_event_light: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == alsd_pkg::EV_ON || event_res == alsd_pkg::EV_OFF) |->
		light_on == (event_res == alsd_pkg::EV_ON))
		else $error("event does not match light state");

	// Before the ring fills, nothing is decided.
	a_quiet_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !average_valid |->
		event_res == alsd_pkg::EV_NONE && average == 16'd0 && !light_on)
		else $error("decision before ring full");

	// Once full, the ring stays full.
	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && average_valid) ##1 out_valid |-> average_valid)
		else $error("average_valid dropped");

endmodule

bind averaged_light_switch_with_dwell alsd_checker u_alsd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.light_on     (light_on),
	.event_res    (event_res),
	.stamp        (stamp),
	.average      (average),
	.average_valid(average_valid)
);
